[src/mvma_pkg.sv]
// Shared constants and codes for the matrix-vector multiply-accumulate block.
`timescale 1ns / 1ps
package mvma_pkg;

  localparam int MAX_DIM   = 64;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = IDX_W + 1;
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int DATA_W    = 16;
  localparam int FRAC_W    = DATA_W / 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 48;
  localparam int ACC_LO_W  = ACC_W / 2;
  localparam int PLO_W     = DATA_W + ACC_LO_W + 1;
  localparam int PHI_W     = DATA_W + ACC_W - ACC_LO_W;
  localparam int TOT_W     = DATA_W + ACC_W + 2;
  localparam int OUT_SHIFT = 2 * FRAC_W;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_X = 2'd1,
    CMD_LOAD_Y = 2'd2,
    CMD_START  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DIM0      = 3'd0,
    REG_DIM1      = 3'd1,
    REG_TRANSPOSE = 3'd2,
    REG_ALPHA     = 3'd3,
    REG_BETA      = 3'd4
  } reg_e;

  localparam logic [CNT_W-1:0]  DIM_RESET   = CNT_W'(MAX_DIM);
  localparam logic [DATA_W-1:0] SCALE_RESET = DATA_W'(1) << FRAC_W;

  // Limit a size register to the store depth.
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] d);
    if (d > CNT_W'(MAX_DIM)) begin
      return CNT_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

[src/matrix_vector_multiply_accumulate.sv]
// Top level of the matrix-vector multiply-accumulate (GEMV) block.
`timescale 1ns / 1ps
// The block computes out = beta*y + alpha*(A*x), or A transposed times x, in signed Q8.8.
// Items arrive on a valid/ready input channel. A load transfer writes one element of the
// matrix store, the x store or the y store, so loads stream at one per cycle while idle.
// A start transfer with a nonzero output count begins a run that emits one result per
// output index, in rising order, with last set on the final one; the input is held off
// until the run ends. For each output element the multiply-accumulate loop issues one
// read of the matrix memory and the x memory per cycle (n_sum reads); then the read,
// multiply and accumulate stages drain, S_SCALE_LO, S_SCALE_HI and S_SUM form
// alpha*sum + beta*y and round half up, and the result is saturated as the output
// register is loaded. With an empty sum the loop issues no reads and the sum is zero.
// The single read port of the matrix memory sets this pace.
// Results leave through an output register, so a receiver that stalls only holds the
// sequencer at the point where the next result would be loaded; nothing is dropped.
// Configuration uses an APB-style port with registers at byte addresses 0, 4, 8, 12, 16:
// dim0_size, dim1_size, transpose_mode, alpha and beta. Write them only while idle.
// Reset clears the sequencer and the output register and returns the registers to 64, 64,
// 0, 1.0 and 1.0. The stores are not cleared; every entry must be loaded before a run
// reads it.
module matrix_vector_multiply_accumulate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [mvma_pkg::IDX_W-1:0]      first_index_i,
  input  logic [mvma_pkg::IDX_W-1:0]      second_index_i,
  input  logic signed [mvma_pkg::DATA_W-1:0] value_i,
  // Result output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mvma_pkg::IDX_W-1:0]      out_index_o,
  output logic signed [mvma_pkg::DATA_W-1:0] out_value_o,
  output logic                            last_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvma_pkg::PADDR_W-1:0]    paddr,
  input  logic [mvma_pkg::PDATA_W-1:0]    pwdata,
  output logic [mvma_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import mvma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SCALE_LO,
    S_SCALE_HI,
    S_SUM,
    S_EMIT
  } state_e;

  // Configuration registers.
  logic [CNT_W-1:0]         dim0_q, dim1_q;
  logic                     transpose_q;
  logic signed [DATA_W-1:0] alpha_q, beta_q;

  // Run control.
  state_e             state_q;
  logic               run_tr_q;
  logic [CNT_W-1:0]   n_out_q, n_sum_q;
  logic [CNT_W-1:0]   o_q, k_q;
  logic               rd_v_q, prod_v_q;

  // Datapath registers.
  logic signed [DATA_W-1:0] a_rd_q, x_rd_q, y_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [PLO_W-1:0]  plo_q;
  logic signed [PHI_W-1:0]  phi_q;
  logic signed [PROD_W-1:0] by_q;
  logic [TOT_W-1:0]         total_q;

  // Output register.
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_index_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     last_q;

  // Stores.
  logic [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] x_mem [MAX_DIM];
  logic [DATA_W-1:0] y_mem [MAX_DIM];

  logic               in_xfer, cfg_wr;
  logic [2:0]         reg_idx;
  logic               issue;
  logic [MAT_AW-1:0]  a_waddr, a_raddr;
  logic               out_free, is_last;
  logic [TOT_W-1:0]   total_d;
  logic [TOT_W-OUT_SHIFT-1:0] shifted;
  logic [DATA_W-1:0]  sat_value;
  logic [CNT_W-1:0]   start_n_out, start_n_sum;

  localparam logic [TOT_W-1:0] ROUND_BIAS = TOT_W'(1) << (OUT_SHIFT - 1);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_MAC) && (k_q < n_sum_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_last    = (o_q + CNT_W'(1)) == n_out_q;

  // Row-major matrix address: first index selects the row.
  assign a_waddr = {first_index_i, second_index_i};
  assign a_raddr = run_tr_q ? {k_q[IDX_W-1:0], o_q[IDX_W-1:0]}
                            : {o_q[IDX_W-1:0], k_q[IDX_W-1:0]};

  assign start_n_out = transpose_q ? clamp_dim(dim1_q) : clamp_dim(dim0_q);
  assign start_n_sum = transpose_q ? clamp_dim(dim0_q) : clamp_dim(dim1_q);

  // Final combine: alpha*sum is assembled from its two partial products, beta*y is aligned
  // to the same Q.24 scale, and the rounding bias is added.
  assign total_d = {{2{phi_q[PHI_W-1]}}, phi_q, {ACC_LO_W{1'b0}}}
                 + {{(TOT_W-PLO_W){plo_q[PLO_W-1]}}, plo_q}
                 + {{(TOT_W-PROD_W-FRAC_W){by_q[PROD_W-1]}}, by_q, {FRAC_W{1'b0}}}
                 + ROUND_BIAS;

  // Saturation after the arithmetic right shift.
  assign shifted = total_q[TOT_W-1:OUT_SHIFT];
  always_comb begin
    if (!shifted[TOT_W-OUT_SHIFT-1] && (shifted[TOT_W-OUT_SHIFT-2:DATA_W-1] != '0)) begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (shifted[TOT_W-OUT_SHIFT-1]
                 && (shifted[TOT_W-OUT_SHIFT-2:DATA_W-1] != '1)) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = shifted[DATA_W-1:0];
    end
  end

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    unique case (reg_idx)
      REG_DIM0:      prdata = PDATA_W'(dim0_q);
      REG_DIM1:      prdata = PDATA_W'(dim1_q);
      REG_TRANSPOSE: prdata = PDATA_W'(transpose_q);
      REG_ALPHA:     prdata = PDATA_W'(unsigned'(alpha_q));
      REG_BETA:      prdata = PDATA_W'(unsigned'(beta_q));
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim0_q      <= DIM_RESET;
      dim1_q      <= DIM_RESET;
      transpose_q <= 1'b0;
      alpha_q     <= SCALE_RESET;
      beta_q      <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DIM0:      dim0_q      <= pwdata[CNT_W-1:0];
        REG_DIM1:      dim1_q      <= pwdata[CNT_W-1:0];
        REG_TRANSPOSE: transpose_q <= pwdata[0];
        REG_ALPHA:     alpha_q     <= pwdata[DATA_W-1:0];
        REG_BETA:      beta_q      <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (command_i == CMD_LOAD_A)) begin
      a_mem[a_waddr] <= value_i;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (command_i == CMD_LOAD_X)) begin
      x_mem[first_index_i] <= value_i;
    end
    x_rd_q <= x_mem[k_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (command_i == CMD_LOAD_Y)) begin
      y_mem[first_index_i] <= value_i;
    end
    y_rd_q <= y_mem[o_q[IDX_W-1:0]];
  end

  // Sequencer, multiply-accumulate pipeline and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_tr_q    <= 1'b0;
      n_out_q     <= '0;
      n_sum_q     <= '0;
      o_q         <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      plo_q       <= '0;
      phi_q       <= '0;
      by_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_value_q <= '0;
      last_q      <= 1'b0;
    end else begin
      // In S_EMIT the output register is reloaded below whenever the old result leaves.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      rd_v_q   <= issue;
      prod_v_q <= rd_v_q;
      if (rd_v_q) begin
        prod_q <= a_rd_q * x_rd_q;
      end
      if (prod_v_q) begin
        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && (command_i == CMD_START) && (start_n_out != '0)) begin
            run_tr_q <= transpose_q;
            n_out_q  <= start_n_out;
            n_sum_q  <= start_n_sum;
            o_q      <= '0;
            k_q      <= '0;
            acc_q    <= '0;
            state_q  <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            k_q <= k_q + CNT_W'(1);
          end else if (!rd_v_q && !prod_v_q) begin
            state_q <= S_SCALE_LO;
          end
        end
        S_SCALE_LO: begin
          plo_q   <= alpha_q * $signed({1'b0, acc_q[ACC_LO_W-1:0]});
          by_q    <= beta_q * y_rd_q;
          state_q <= S_SCALE_HI;
        end
        S_SCALE_HI: begin
          phi_q   <= alpha_q * $signed(acc_q[ACC_W-1:ACC_LO_W]);
          state_q <= S_SUM;
        end
        S_SUM: begin
          total_q <= total_d;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_index_q <= o_q[IDX_W-1:0];
            out_value_q <= sat_value;
            last_q      <= is_last;
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              o_q     <= o_q + CNT_W'(1);
              k_q     <= '0;
              acc_q   <= '0;
              state_q <= S_MAC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule
